// ===== rtl/core/srpl_pkg.sv =====
// Shared types and constants for the square region point lookup block.
// No dependencies; imported by the top level.
package srpl_pkg;

    // Parameter defaults
    localparam int MAX_REGIONS_DEF = 256;
    localparam int COORD_BITS_DEF  = 20;

    // Fixed port widths
    localparam int COUNT_W = 9;
    localparam int INDEX_W = 8;
    localparam int KIND_W  = 2;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_CONTAINED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NEAREST   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE      = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/srpl_eval.sv =====
// Per-entry evaluation stage: containment test and Manhattan corner distance.
// Standalone; results registered the cycle after the entry is presented.
module srpl_eval #(
    parameter int COORD_BITS = 20
) (
    input  logic                         clk,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    input  logic        [COORD_BITS-2:0] side,
    input  logic signed [COORD_BITS-1:0] qx,
    input  logic signed [COORD_BITS-1:0] qy,
    output logic                         hit,
    output logic        [COORD_BITS+1:0] distance
);

    localparam int CB = COORD_BITS;

    logic signed [CB:0]   cx_e, cy_e, qx_e, qy_e;
    logic signed [CB:0]   x_hi, y_hi;
    logic signed [CB:0]   dx, dy;
    logic        [CB:0]   adx, ady;
    logic                 hit_next;
    logic        [CB+1:0] dist_next;
    logic                 hit_reg;
    logic        [CB+1:0] dist_reg;

    always_comb
    begin
        cx_e = {cx[CB-1], cx};
        cy_e = {cy[CB-1], cy};
        qx_e = {qx[CB-1], qx};
        qy_e = {qy[CB-1], qy};
        // upper edges, exact (one extra bit)
        x_hi = cx_e + $signed({2'b00, side});
        y_hi = cy_e + $signed({2'b00, side});
        hit_next = (qx_e >= cx_e) && (qx_e <= x_hi) &&
                   (qy_e >= cy_e) && (qy_e <= y_hi);
        dx  = cx_e - qx_e;
        dy  = cy_e - qy_e;
        adx = dx[CB] ? $unsigned(-dx) : $unsigned(dx);
        ady = dy[CB] ? $unsigned(-dy) : $unsigned(dy);
        dist_next = {1'b0, adx} + {1'b0, ady};
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= hit_next;
        dist_reg <= dist_next;
    end

    assign hit      = hit_reg;
    assign distance = dist_reg;

endmodule

// ===== rtl/core/square_region_point_lookup_top.sv =====
// Top level of the square region point lookup: region table memory, scan
// sequencer, best-match tracking and output register. Uses srpl_pkg, srpl_eval.
//
// Usage:
//   Input channel (in_valid / in_stall): one item per command. cmd = write
//   stores {corner_x, corner_y, side_length} at entry_index and gives no
//   result; slots at or above MAX_REGIONS are dropped. cmd = query scans
//   entries 0 .. n-1, n = min(region_count, MAX_REGIONS), and gives one
//   result item (match_kind, region_index) on the output channel.
//   Config: cfg_we / cfg_data write region_count; write it only when idle.
//   Timing: a write leaves the input channel ready for the next item. A
//   query reads one table entry per cycle through the single memory read
//   port into the read register and the eval stage (no reads with an empty
//   table); the next item is taken only once the result has loaded into the
//   output register.
//   The scan runs over all n entries, and a containing region wins over the
//   nearest corner regardless of where in the scan it appears.
//   Stall: the result sits in the output register while out_stall is high;
//   new items are still accepted meanwhile, but a finished query waits for
//   the output register to drain before it loads.
//   Reset: clears control state and region_count; table contents stay
//   undefined until written.
module square_region_point_lookup_top
    import srpl_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_we,
    input  logic [COUNT_W-1:0]           cfg_data,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         cmd,
    input  logic [INDEX_W-1:0]           entry_index,
    input  logic signed [COORD_BITS-1:0] corner_x,
    input  logic signed [COORD_BITS-1:0] corner_y,
    input  logic [COORD_BITS-2:0]        side_length,
    input  logic signed [COORD_BITS-1:0] query_x,
    input  logic signed [COORD_BITS-1:0] query_y,
    input  logic                         use_nearest,
    // output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [KIND_W-1:0]            match_kind,
    output logic [INDEX_W-1:0]           region_index
);

    localparam int CB = COORD_BITS;
    localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int MW = 3 * CB - 1;
    localparam int DW = CB + 2;

    // ---------------------------------------------------------------
    // Config register
    // ---------------------------------------------------------------
    logic [COUNT_W-1:0] region_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            region_count_reg <= cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // Handshake and state
    // ---------------------------------------------------------------
    state_t state_reg, state_next;

    logic in_acc, out_acc, is_query, is_write, wr_in_range;
    logic [CW-1:0] n_eff;

    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid && !out_stall;
    assign is_query = in_acc && (cmd == CMD_QUERY);
    assign is_write = in_acc && (cmd == CMD_WRITE);
    assign wr_in_range = (32'(entry_index) < 32'(MAX_REGIONS));
    assign n_eff = (32'(region_count_reg) > 32'(MAX_REGIONS)) ? CW'(MAX_REGIONS)
                                                              : CW'(region_count_reg);

    // query context
    logic signed [CB-1:0] qx_reg, qy_reg;
    logic                 near_reg;
    logic [CW-1:0]        n_reg;

    always_ff @(posedge clk)
    begin
        if (is_query)
        begin
            qx_reg   <= query_x;
            qy_reg   <= query_y;
            near_reg <= use_nearest;
            n_reg    <= n_eff;
        end
    end

    // ---------------------------------------------------------------
    // Region table: one write port (commands), one read port (scan)
    // ---------------------------------------------------------------
    logic [MW-1:0] table_mem [MAX_REGIONS];
    logic [MW-1:0] rd_data_reg;
    logic [AW-1:0] iss_reg;
    logic          issuing_reg;
    logic          iss_last;

    assign iss_last = ((CW'(iss_reg) + CW'(1)) == n_reg);

    always_ff @(posedge clk)
    begin
        if (is_write && wr_in_range)
        begin
            table_mem[AW'(entry_index)] <= {corner_x, corner_y, side_length};
        end
        if (issuing_reg)
        begin
            rd_data_reg <= table_mem[iss_reg];
        end
    end

    // scan issue counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg <= 1'b0;
            iss_reg     <= '0;
        end
        else if (is_query)
        begin
            issuing_reg <= (n_eff != '0);
            iss_reg     <= '0;
        end
        else if (issuing_reg)
        begin
            issuing_reg <= !iss_last;
            iss_reg     <= iss_reg + AW'(1);
        end
    end

    // ---------------------------------------------------------------
    // Pipeline tags: p1 = memory data, p2 = evaluated entry
    // ---------------------------------------------------------------
    logic          p1_valid_reg, p1_last_reg, p2_valid_reg, p2_last_reg;
    logic [AW-1:0] p1_idx_reg, p2_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= issuing_reg;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_idx_reg  <= iss_reg;
        p1_last_reg <= iss_last;
        p2_idx_reg  <= p1_idx_reg;
        p2_last_reg <= p1_last_reg;
    end

    logic          ev_hit;
    logic [DW-1:0] ev_dist;

    srpl_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_eval (
        .clk      (clk),
        .cx       (rd_data_reg[MW-1 -: CB]),
        .cy       (rd_data_reg[MW-CB-1 -: CB]),
        .side     (rd_data_reg[CB-2:0]),
        .qx       (qx_reg),
        .qy       (qy_reg),
        .hit      (ev_hit),
        .distance (ev_dist)
    );

    // ---------------------------------------------------------------
    // Best-match tracking: first hit, and least distance (first on ties)
    // ---------------------------------------------------------------
    logic          found_reg;
    logic [AW-1:0] hit_idx_reg, best_idx_reg;
    logic [DW-1:0] best_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (is_query)
        begin
            found_reg <= 1'b0;
        end
        else if (p2_valid_reg && ev_hit)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p2_valid_reg && ev_hit && !found_reg)
        begin
            hit_idx_reg <= p2_idx_reg;
        end
        if (p2_valid_reg && ((p2_idx_reg == '0) || (ev_dist < best_dist_reg)))
        begin
            best_idx_reg  <= p2_idx_reg;
            best_dist_reg <= ev_dist;
        end
    end

    // ---------------------------------------------------------------
    // State machine
    // ---------------------------------------------------------------
    logic               load_out;
    logic [KIND_W-1:0]  res_kind;
    logic [INDEX_W-1:0] res_index;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_query)
                begin
                    state_next = (n_eff == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (p2_valid_reg && p2_last_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        load_out  = (state_reg == ST_DONE) && (!out_valid || !out_stall);
        res_kind  = KIND_NONE;
        res_index = '0;
        if (found_reg)
        begin
            res_kind  = KIND_CONTAINED;
            res_index = INDEX_W'(hit_idx_reg);
        end
        else if (near_reg && (n_reg != '0))
        begin
            res_kind  = KIND_NEAREST;
            res_index = INDEX_W'(best_idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic               out_valid_reg;
    logic [KIND_W-1:0]  match_kind_reg;
    logic [INDEX_W-1:0] region_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_acc)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            match_kind_reg   <= res_kind;
            region_index_reg <= res_index;
        end
    end

    assign out_valid    = out_valid_reg;
    assign match_kind   = match_kind_reg;
    assign region_index = region_index_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_eval_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid_reg |-> (state_reg == ST_SCAN))
        else $error("evaluated entry outside of scan");

    a_pipe_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg |=> p2_valid_reg)
        else $error("entry lost between read and evaluate");

    a_scan_not_starved: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issuing_reg || p1_valid_reg || p2_valid_reg))
        else $error("scan state with empty pipeline");

    a_empty_table_done: assert property (@(posedge clk) disable iff (!rst_n)
        (is_query && (n_eff == '0)) |=> (state_reg == ST_DONE))
        else $error("empty-table query did not finish at once");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && found_reg) |-> (CW'(hit_idx_reg) < n_reg))
        else $error("containing index beyond region count");

endmodule
